// File: rtl/gvsp_pkg.sv
// ----------------------------------------------------------------------------
// gvsp_pkg
// Shared types and constants for the generational voice slot pool.
// ----------------------------------------------------------------------------
package gvsp_pkg;

	localparam int DEFAULT_VOICES = 64;
	localparam int GEN_W          = 32;
	localparam int FRAMES_W       = 32;
	localparam int TICK_W         = 16;
	localparam int SOUND_W        = 8;
	localparam int LOADED_W       = 9;
	localparam int HSLOT_W        = 32;
	localparam int OUT_SLOT_W     = 6;
	localparam int COUNT_W        = 7;

	localparam logic [GEN_W-1:0]    GEN_RESET    = GEN_W'(1);
	localparam logic [LOADED_W-1:0] LOADED_RESET = LOADED_W'(1);

	typedef enum logic [1:0] {
		OP_PLAY     = 2'd0,
		OP_STOP     = 2'd1,
		OP_STOP_ALL = 2'd2,
		OP_TICK     = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic                active;
		logic                pending;
		logic [GEN_W-1:0]    gen;
		logic [FRAMES_W-1:0] frames;
	} slot_word_t;

	typedef struct packed {
		logic       en;
		slot_word_t data;
	} ram_wr_t;

endpackage

// File: rtl/gvsp_slot_ram.sv
// ----------------------------------------------------------------------------
// gvsp_slot_ram
// Per-slot word store (active flag, stop request, generation, frames left),
// one read and one write port, registered read. Entries never written read as
// the reset word: inactive, no stop request, generation one.
// ----------------------------------------------------------------------------
module gvsp_slot_ram #(
	parameter int VOICES = gvsp_pkg::DEFAULT_VOICES,
	parameter int AW     = $clog2(VOICES)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 rd_en,
	input  logic [AW-1:0]        rd_addr,
	output gvsp_pkg::slot_word_t rd_word,
	input  gvsp_pkg::ram_wr_t    wr,
	input  logic [AW-1:0]        wr_addr
);
	import gvsp_pkg::*;

	slot_word_t        mem [VOICES];
	slot_word_t        word_q;
	logic [VOICES-1:0] written_q;
	logic              known_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr_addr] <= wr.data;
		end
		if (rd_en) begin
			word_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
			known_q   <= 1'b0;
		end else begin
			if (wr.en) begin
				written_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				known_q <= written_q[rd_addr];
			end
		end
	end

	always_comb begin
		rd_word = word_q;
		if (!known_q) begin
			rd_word.active  = 1'b0;
			rd_word.pending = 1'b0;
			rd_word.gen     = GEN_RESET;
		end
	end

endmodule

// File: rtl/gvsp_ctrl.sv
// ----------------------------------------------------------------------------
// gvsp_ctrl
// Item sequencer: validates items, walks slots through the slot store with a
// read-modify-write stage, keeps the result register.
// ----------------------------------------------------------------------------
module gvsp_ctrl #(
	parameter int VOICES = gvsp_pkg::DEFAULT_VOICES,
	parameter int AW     = $clog2(VOICES)
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [gvsp_pkg::LOADED_W-1:0]        cfg_wdata,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [1:0]                           opcode,
	input  logic [gvsp_pkg::SOUND_W-1:0]         sound_index,
	input  logic [gvsp_pkg::FRAMES_W-1:0]        sound_frames,
	input  logic [gvsp_pkg::HSLOT_W-1:0]         handle_slot,
	input  logic [gvsp_pkg::GEN_W-1:0]           handle_generation,
	input  logic [gvsp_pkg::TICK_W-1:0]          tick_frames,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic                                 ok,
	output logic [gvsp_pkg::OUT_SLOT_W-1:0]      out_slot,
	output logic [gvsp_pkg::GEN_W-1:0]           out_generation,
	output logic [gvsp_pkg::COUNT_W-1:0]         voice_count,
	output logic                                 rd_en,
	output logic [AW-1:0]                        rd_addr,
	input  gvsp_pkg::slot_word_t                 rd_word,
	output gvsp_pkg::ram_wr_t                    wr,
	output logic [AW-1:0]                        wr_addr
);
	import gvsp_pkg::*;

	localparam int CW = $clog2(VOICES + 1);

	state_t               state_q, state_d;
	op_t                  op_in;
	logic                 reject;
	logic                 accept;
	logic                 out_load;

	logic [LOADED_W-1:0]  loaded_q;
	op_t                  op_q;
	logic [FRAMES_W-1:0]  frames_q;
	logic [GEN_W-1:0]     hgen_q;
	logic [TICK_W-1:0]    tick_q;

	logic                 issue_q;
	logic                 single_q;
	logic [AW-1:0]        rd_idx_q;
	logic                 is_last;

	logic                 vld_s1;
	logic                 last_s1;
	logic [AW-1:0]        idx_s1;

	logic                 found_q;

	logic                 res_ok_q;
	logic [AW-1:0]        res_slot_q;
	logic [GEN_W-1:0]     res_gen_q;
	logic [CW-1:0]        res_cnt_q;

	logic                 out_valid_q;
	logic                 out_ok_q;
	logic [AW-1:0]        out_slot_q;
	logic [GEN_W-1:0]     out_gen_q;
	logic [CW-1:0]        out_cnt_q;

	logic                 act;
	logic                 claim;
	logic                 hit;
	logic                 free;
	logic                 inc;
	logic [FRAMES_W-1:0]  left;

	assign op_in    = op_t'(opcode);
	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_load = (state_q == ST_FIN) && (!out_valid_q || out_ready);
	assign is_last  = single_q || (rd_idx_q == AW'(VOICES - 1));

	always_comb begin
		unique case (op_in)
			OP_PLAY: begin
				reject = (sound_index == '0) ||
					({1'b0, sound_index} >= loaded_q) ||
					(sound_frames == '0);
			end
			OP_STOP: begin
				reject = ((handle_slot == '0) && (handle_generation == '0)) ||
					(handle_slot >= HSLOT_W'(VOICES));
			end
			OP_STOP_ALL, OP_TICK: begin
				reject = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = reject ? ST_FIN : ST_WALK;
				end
			end
			ST_WALK: begin
				if (vld_s1 && last_s1) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (!out_valid_q || out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// slot store read
	assign rd_en   = issue_q;
	assign rd_addr = rd_idx_q;
	assign wr_addr = idx_s1;
	assign act     = rd_word.active;
	assign left    = (rd_word.frames > FRAMES_W'(tick_q)) ?
		(rd_word.frames - FRAMES_W'(tick_q)) : '0;

	// modify stage
	always_comb begin
		wr    = '0;
		claim = 1'b0;
		hit   = 1'b0;
		free  = 1'b0;
		inc   = 1'b0;
		if (vld_s1) begin
			unique case (op_q)
				OP_PLAY: begin
					if (!act && !found_q) begin
						claim           = 1'b1;
						wr.en           = 1'b1;
						wr.data.active  = 1'b1;
						wr.data.pending = 1'b0;
						wr.data.gen     = rd_word.gen;
						wr.data.frames  = frames_q;
					end
				end
				OP_STOP: begin
					if (rd_word.gen == hgen_q) begin
						hit             = 1'b1;
						wr.en           = 1'b1;
						wr.data         = rd_word;
						wr.data.pending = 1'b1;
					end
				end
				OP_STOP_ALL: begin
					if (act) begin
						inc             = 1'b1;
						wr.en           = 1'b1;
						wr.data         = rd_word;
						wr.data.pending = 1'b1;
					end
				end
				OP_TICK: begin
					if (act) begin
						wr.en = 1'b1;
						if (rd_word.pending || (left == '0)) begin
							free            = 1'b1;
							wr.data.active  = 1'b0;
							wr.data.pending = 1'b0;
							wr.data.gen     = rd_word.gen + GEN_W'(1);
							wr.data.frames  = left;
						end else begin
							inc             = 1'b1;
							wr.data.active  = 1'b1;
							wr.data.pending = rd_word.pending;
							wr.data.gen     = rd_word.gen;
							wr.data.frames  = left;
						end
					end
				end
			endcase
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded_q    <= LOADED_RESET;
			issue_q     <= 1'b0;
			vld_s1      <= 1'b0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				loaded_q <= cfg_wdata;
			end
			vld_s1 <= issue_q;
			if (accept) begin
				issue_q <= !reject;
				found_q <= 1'b0;
			end else begin
				if (issue_q && is_last) begin
					issue_q <= 1'b0;
				end
				if (claim) begin
					found_q <= 1'b1;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q       <= op_in;
			frames_q   <= sound_frames;
			hgen_q     <= handle_generation;
			tick_q     <= tick_frames;
			single_q   <= (op_in == OP_STOP);
			rd_idx_q   <= (op_in == OP_STOP) ? handle_slot[AW-1:0] : '0;
			res_ok_q   <= 1'b0;
			res_slot_q <= '0;
			res_gen_q  <= '0;
			res_cnt_q  <= '0;
		end else begin
			if (issue_q) begin
				rd_idx_q <= rd_idx_q + 1'b1;
			end
			if (claim) begin
				res_ok_q   <= 1'b1;
				res_slot_q <= idx_s1;
				res_gen_q  <= rd_word.gen;
			end
			if (hit) begin
				res_ok_q <= 1'b1;
			end
			if (inc) begin
				res_cnt_q <= res_cnt_q + 1'b1;
			end
		end
		idx_s1  <= rd_idx_q;
		last_s1 <= is_last;
		if (out_load) begin
			out_ok_q   <= res_ok_q;
			out_slot_q <= res_slot_q;
			out_gen_q  <= res_gen_q;
			out_cnt_q  <= res_cnt_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign ok             = out_ok_q;
	assign out_slot       = OUT_SLOT_W'(out_slot_q);
	assign out_generation = out_gen_q;
	assign voice_count    = COUNT_W'(out_cnt_q);

endmodule

// File: rtl/generational_voice_slot_pool.sv
// Flow: play, stop-all and tick walk every slot through the slot store, one
// per cycle; a stop reads only its handle's slot and a rejected item skips the
// walk. One item is in work at a time and the next is taken the cycle after the
// result loads; a result held by the receiver delays that load.
// Reset: no slot active, every generation one, sounds_loaded one; no clearing.
// ----------------------------------------------------------------------------
// generational_voice_slot_pool
// Pool of voice slots handed out through generation-tagged handles.
// ----------------------------------------------------------------------------
module generational_voice_slot_pool #(
	parameter int VOICES = gvsp_pkg::DEFAULT_VOICES
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [gvsp_pkg::LOADED_W-1:0]        cfg_wdata,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [1:0]                           opcode,
	input  logic [gvsp_pkg::SOUND_W-1:0]         sound_index,
	input  logic [gvsp_pkg::FRAMES_W-1:0]        sound_frames,
	input  logic [gvsp_pkg::HSLOT_W-1:0]         handle_slot,
	input  logic [gvsp_pkg::GEN_W-1:0]           handle_generation,
	input  logic [gvsp_pkg::TICK_W-1:0]          tick_frames,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic                                 ok,
	output logic [gvsp_pkg::OUT_SLOT_W-1:0]      out_slot,
	output logic [gvsp_pkg::GEN_W-1:0]           out_generation,
	output logic [gvsp_pkg::COUNT_W-1:0]         voice_count
);
	import gvsp_pkg::*;

	localparam int AW = $clog2(VOICES);

	logic          rd_en;
	logic [AW-1:0] rd_addr;
	slot_word_t    rd_word;
	ram_wr_t       wr;
	logic [AW-1:0] wr_addr;

	gvsp_ctrl #(
		.VOICES(VOICES),
		.AW    (AW)
	) u_ctrl (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_wdata        (cfg_wdata),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.opcode           (opcode),
		.sound_index      (sound_index),
		.sound_frames     (sound_frames),
		.handle_slot      (handle_slot),
		.handle_generation(handle_generation),
		.tick_frames      (tick_frames),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.ok               (ok),
		.out_slot         (out_slot),
		.out_generation   (out_generation),
		.voice_count      (voice_count),
		.rd_en            (rd_en),
		.rd_addr          (rd_addr),
		.rd_word          (rd_word),
		.wr               (wr),
		.wr_addr          (wr_addr)
	);

	gvsp_slot_ram #(
		.VOICES(VOICES),
		.AW    (AW)
	) u_slot_ram (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_word(rd_word),
		.wr     (wr),
		.wr_addr(wr_addr)
	);

endmodule
